>>> hdl/rdts_pkg.sv
// Package for the range DFA token scanner: widths, default sizes, function
// codes and the result struct. No dependencies.
`default_nettype none
package rdts_pkg;
  localparam int CharW   = 21;
  localparam int SymW    = 8;
  localparam int LenW    = 16;
  localparam int FuncW   = 3;
  localparam int AddrW   = 11;
  localparam int ValW    = 11;
  localparam int MachW   = 2;
  localparam int StateW  = 8;

  localparam int DefMachines = 4;
  localparam int DefStates   = 256;
  localparam int DefRanges   = 2048;
  localparam int DefSymbols  = 256;

  localparam logic [FuncW-1:0] FUNC_LOAD_INDEX  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_LOAD_RANGE  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_LOAD_ACCEPT = 3'd2;
  localparam logic [FuncW-1:0] FUNC_LOAD_GREEDY = 3'd3;
  localparam logic [FuncW-1:0] FUNC_START       = 3'd4;
  localparam logic [FuncW-1:0] FUNC_NEXT        = 3'd5;

  localparam logic [LenW-1:0] LenMax = '1;

  typedef struct packed {
    logic [SymW-1:0] token_symbol;
    logic [LenW-1:0] token_length;
    logic            matched;
  } result_t;
endpackage
`default_nettype wire

>>> hdl/rdts_if.sv
// Valid/ready channel interfaces for the scanner: input word, result word
// and configuration write. Depends on rdts_pkg.
`default_nettype none
interface rdts_in_if;
  import rdts_pkg::*;
  logic valid;
  logic ready;
  logic [FuncW-1:0]  func;
  logic [AddrW-1:0]  table_addr;
  logic [CharW-1:0]  low_char;
  logic [CharW-1:0]  high_char;
  logic [StateW-1:0] target_state;
  logic              list_end;
  logic [ValW-1:0]   table_value;
  logic [MachW-1:0]  machine;
  logic [CharW-1:0]  character;
  logic              end_of_input;
  modport source (output valid, func, table_addr, low_char, high_char, target_state,
                  list_end, table_value, machine, character, end_of_input, input ready);
  modport sink (input valid, func, table_addr, low_char, high_char, target_state,
                list_end, table_value, machine, character, end_of_input, output ready);
endinterface

interface rdts_out_if;
  import rdts_pkg::*;
  logic valid;
  logic ready;
  logic [SymW-1:0] token_symbol;
  logic [LenW-1:0] token_length;
  logic            matched;
  modport source (output valid, token_symbol, token_length, matched, input ready);
  modport sink (input valid, token_symbol, token_length, matched, output ready);
endinterface

interface rdts_cfg_if;
  import rdts_pkg::*;
  logic valid;
  logic ready;
  logic [SymW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hdl/rdts_range_cmp.sv
// Shared range compare unit: tests one character against one range entry.
// Depends on rdts_pkg.
`default_nettype none
module rdts_range_cmp (
  input  wire logic [rdts_pkg::CharW-1:0] character,
  input  wire logic [rdts_pkg::CharW-1:0] low_char,
  input  wire logic [rdts_pkg::CharW-1:0] high_char,
  output logic                            hit
);
  import rdts_pkg::*;
  // inclusive bounds check
  assign hit = (character >= low_char) && (character <= high_char);
endmodule
`default_nettype wire

>>> hdl/range_dfa_token_scanner.sv
// Range DFA token scanner. Load words write their table without leaving
// idle. A character word walks its state's list, reading range entries up
// to a hit or the terminator: every entry goes through the single range_mem
// read port and the one shared compare unit, one entry at a time. A matching
// range then goes through the accept and greedy lookups. A word that ends a
// scan leaves its result in an output register, held there while the
// receiver stalls. Tables are memories with registered reads; entries never
// written read as anything. The input is not ready while a word is in work
// or a result waits. No clearing pass is needed after reset.
`default_nettype none
module range_dfa_token_scanner #(
  parameter int NUM_MACHINES = rdts_pkg::DefMachines,
  parameter int NUM_STATES   = rdts_pkg::DefStates,
  parameter int NUM_RANGES   = rdts_pkg::DefRanges,
  parameter int NUM_SYMBOLS  = rdts_pkg::DefSymbols
) (
  input wire logic clk,
  input wire logic rst,
  rdts_in_if.sink   in_ch,
  rdts_out_if.source out_ch,
  rdts_cfg_if.sink  cfg
);
  import rdts_pkg::*;

  localparam int StDepth = NUM_MACHINES * NUM_STATES;
  localparam int SaW     = (StDepth > 1) ? $clog2(StDepth) : 1;
  localparam int RaW     = $clog2(NUM_RANGES);
  localparam int SyW     = $clog2(NUM_SYMBOLS);
  localparam int RangeW  = 2 * CharW + StateW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_IDX   = 3'd1;  // index read issued
  localparam logic [2:0] S_RRD   = 3'd2;  // range read issued
  localparam logic [2:0] S_CMP   = 3'd3;  // compare range entry
  localparam logic [2:0] S_ACC   = 3'd4;  // accept read issued
  localparam logic [2:0] S_GRD   = 3'd5;  // greedy data back
  localparam logic [2:0] S_OUT   = 3'd6;  // result waiting
  localparam logic [2:0] S_SYM   = 3'd7;  // accept data back, greedy read issued

  // memories
  logic [ValW-1:0]   index_mem  [StDepth];
  logic [RangeW-1:0] range_mem  [NUM_RANGES];
  logic [8:0]        accept_mem [StDepth];
  logic              greedy_mem [NUM_SYMBOLS];

  logic [ValW-1:0]   index_q;
  logic [RangeW-1:0] range_q;
  logic [8:0]        accept_q;
  logic              greedy_q;

  logic [2:0]        state;
  logic [StateW-1:0] current_state;
  logic [MachW-1:0]  active_machine;
  logic [LenW-1:0]   scan_length;
  logic              best_valid;
  logic [SymW-1:0]   best_symbol;
  logic [LenW-1:0]   best_length;
  logic              scanning;
  logic [SymW-1:0]   end_symbol;
  logic [CharW-1:0]  char_q;
  logic [16:0]       ridx;     // range pointer, bit 16 up means past the end
  logic [StateW-1:0] tgt_q;
  logic              tgt_ok;
  logic [SaW-1:0]    ta_addr;
  logic [8:0]        sym_q;
  result_t           res;

  logic              in_fire;
  logic              hit;
  logic              r_last;
  logic [CharW-1:0]  r_lo, r_hi;
  logic [StateW-1:0] r_tgt;
  logic [31:0]       sa_full, ta_full;
  logic              sa_ok;
  logic [16:0]       ridx_start;
  logic [16:0]       ridx_rd;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.token_symbol = res.token_symbol;
  assign out_ch.token_length = res.token_length;
  assign out_ch.matched      = res.matched;

  assign {r_lo, r_hi, r_tgt, r_last} = range_q;

  rdts_range_cmp u_cmp (.character(char_q), .low_char(r_lo), .high_char(r_hi), .hit(hit));

  // state address of current state, target address of matched target
  assign sa_full = 32'(active_machine) * 32'(NUM_STATES) + 32'(current_state);
  assign sa_ok   = (32'(current_state) < 32'(NUM_STATES)) && (sa_full < 32'(StDepth));
  assign ta_full = 32'(active_machine) * 32'(NUM_STATES) + 32'(r_tgt);
  assign ridx_start = sa_ok ? 17'(index_q) : 17'd0;
  // first read of a walk takes the list start straight from the index
  assign ridx_rd = (ridx == 17'h1ffff) ? ridx_start : ridx;

  // end symbol register
  always_ff @(posedge clk) begin
    if (rst) begin
      end_symbol <= '0;
    end else if (cfg.valid) begin
      end_symbol <= cfg.data;
    end
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_ch.func == FUNC_LOAD_INDEX && 32'(in_ch.table_addr) < 32'(StDepth))
        index_mem[SaW'(in_ch.table_addr)] <= in_ch.table_value;
      if (in_ch.func == FUNC_LOAD_RANGE && 32'(in_ch.table_addr) < 32'(NUM_RANGES))
        range_mem[RaW'(in_ch.table_addr)] <= {in_ch.low_char, in_ch.high_char,
                                              in_ch.target_state, in_ch.list_end};
      if (in_ch.func == FUNC_LOAD_ACCEPT && 32'(in_ch.table_addr) < 32'(StDepth))
        accept_mem[SaW'(in_ch.table_addr)] <= in_ch.table_value[8:0];
      if (in_ch.func == FUNC_LOAD_GREEDY && 32'(in_ch.table_addr) < 32'(NUM_SYMBOLS))
        greedy_mem[SyW'(in_ch.table_addr)] <= in_ch.table_value[0];
    end
    index_q  <= index_mem[SaW'(sa_full)];
    range_q  <= range_mem[RaW'(ridx_rd)];
    accept_q <= accept_mem[ta_addr];
    greedy_q <= greedy_mem[SyW'(accept_q - 9'd1)];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      current_state  <= '0;
      active_machine <= '0;
      scan_length    <= '0;
      best_valid     <= 1'b0;
      best_length    <= '0;
      scanning       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            char_q <= in_ch.character;
            if (in_ch.func == FUNC_START) begin
              active_machine <= in_ch.machine;
              current_state  <= '0;
              scan_length    <= '0;
              best_valid     <= 1'b0;
              best_length    <= '0;
              if (in_ch.end_of_input) begin
                scanning <= 1'b0;
                res      <= '{token_symbol: end_symbol, token_length: '0, matched: 1'b1};
                state    <= S_OUT;
              end else begin
                scanning <= 1'b1;
                state    <= S_IDX;
              end
            end else if (in_ch.func == FUNC_NEXT && scanning) begin
              if (in_ch.end_of_input) begin
                scanning <= 1'b0;
                res <= '{token_symbol: best_valid ? best_symbol : '0,
                         token_length: best_valid ? best_length : '0, matched: best_valid};
                state <= S_OUT;
              end else begin
                state <= S_IDX;
              end
            end
          end
        end
        S_IDX: begin
          // wait for the index read; the first range read follows in S_RRD
          state <= S_RRD;
        end
        S_RRD: begin
          if (ridx == 17'h1ffff) begin
            ridx  <= ridx_start;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (ridx[16] || 32'(ridx) >= 32'(NUM_RANGES) || r_last) begin
            // dead state
            scanning <= 1'b0;
            res <= '{token_symbol: best_valid ? best_symbol : '0,
                     token_length: best_valid ? best_length : '0, matched: best_valid};
            state <= S_OUT;
          end else if (hit) begin
            tgt_q   <= r_tgt;
            tgt_ok  <= (32'(r_tgt) < 32'(NUM_STATES)) && (ta_full < 32'(StDepth));
            ta_addr <= SaW'(ta_full);
            state   <= S_ACC;
          end else begin
            ridx  <= ridx + 17'd1;
            state <= S_RRD;
          end
        end
        S_ACC: begin
          // wait for the accept read
          state <= S_SYM;
        end
        S_SYM: begin
          sym_q <= tgt_ok ? accept_q : 9'd0;
          state <= S_GRD;
        end
        S_GRD: begin
          current_state <= tgt_q;
          if (scan_length != LenMax) scan_length <= scan_length + 16'd1;
          if (sym_q != 9'd0) begin
            best_valid  <= 1'b1;
            best_symbol <= SymW'(sym_q - 9'd1);
            best_length <= (scan_length != LenMax) ? scan_length + 16'd1 : LenMax;
            if (SymW'(sym_q - 9'd1) == end_symbol && (sym_q - 9'd1) < 9'd256
                || !(32'(sym_q - 9'd1) < 32'(NUM_SYMBOLS) && greedy_q)) begin
              scanning <= 1'b0;
              res <= '{token_symbol: SymW'(sym_q - 9'd1),
                       token_length: (scan_length != LenMax) ? scan_length + 16'd1 : LenMax,
                       matched: 1'b1};
              state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // range pointer: mark unloaded on entering a walk
      if (state == S_IDX) ridx <= 17'h1ffff;
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("input ready while result waits");
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !scanning) else $error("result while scan still live");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.matched |-> out_ch.token_length == '0)
    else $error("no-match result with length");
endmodule
`default_nettype wire
